@@ rtl/core/etnf_pkg.sv @@
// ============================================================================
// etnf_pkg
// Shared constants, types and arithmetic helpers of the equal-temperament
// note-to-frequency converter.
// ============================================================================
package etnf_pkg;

    // Fixed-point formats.
    localparam int FRACTION_BITS   = 16;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
    localparam int SERIES_TERMS    = 24;
    localparam int REM_BITS        = $clog2(SERIES_TERMS);

    // Q62 constants.
    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LN2_Q62 = 64'h2C5C_85FD_F473_DE6B;

    // Register reset values and scaling.
    localparam logic [10:0] STEPS_RESET = 11'd12;
    localparam logic [31:0] ROOT_RESET  = 32'(64'd440 << FRACTION_BITS);
    localparam logic [31:0] CENTS_SCALE = 32'd307200;
    localparam logic [31:0] FREQ_MAX    = 32'hFFFF_FFFF;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_STEPS_PER_OCTAVE = 1'b0,
        REG_ROOT_FREQUENCY   = 1'b1
    } cfg_reg_t;

    // Per-item data that rides along with the mantissa computation.
    typedef struct packed {
        logic signed [12:0] octave;
        logic signed [31:0] cents;
    } side_t;

    // Four 32x32 partial products of a 64x64 multiply.
    typedef logic [3:0][63:0] parts_t;

    typedef logic [63:0] pow_table_t [TABLE_DEPTH];

    // One restoring division step: shift in a bit, subtract if it fits.
    // Returns the quotient bit above the new remainder.
    function automatic logic [11:0] div_step(logic [10:0] rem, logic bit_in,
                                             logic [10:0] divisor);
        logic [11:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, divisor}) begin
            return {1'b1, 11'(t - {1'b0, divisor})};
        end else begin
            return {1'b0, t[10:0]};
        end
    endfunction

    // Partial products of a 64x64 multiply, one 32x32 multiplier each.
    function automatic parts_t mul_parts(logic [63:0] a, logic [63:0] b);
        parts_t p;
        p[0] = 64'(a[31:0]) * 64'(b[31:0]);
        p[1] = 64'(a[31:0]) * 64'(b[63:32]);
        p[2] = 64'(a[63:32]) * 64'(b[31:0]);
        p[3] = 64'(a[63:32]) * 64'(b[63:32]);
        return p;
    endfunction

    // Sum of the partial products, rounded half up to Q62.
    function automatic logic [63:0] mul_round(parts_t p);
        logic [127:0] s;
        s = {64'd0, p[0]} + {32'd0, p[1], 32'd0} + {32'd0, p[2], 32'd0}
            + {p[3], 64'd0} + (128'd1 << 61);
        return s[125:62];
    endfunction

    // Elaboration-time helpers for the power table.
    function automatic logic [63:0] q62_mul_exact(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << 61);
        return p[125:62];
    endfunction

    function automatic logic [63:0] q62_exp(logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q62_ONE;
        sum  = Q62_ONE;
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = q62_mul_exact(term, x) / 64'(k);
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic pow_table_t build_pow_table();
        pow_table_t t;
        logic [63:0] frac;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            frac = 64'(k) << (62 - TABLE_ADDR_BITS);
            t[k] = q62_exp(q62_mul_exact(frac, LN2_Q62));
        end
        return t;
    endfunction

    // 2^(i/TABLE_DEPTH) in Q62.
    localparam pow_table_t POW_TABLE = build_pow_table();

endpackage

@@ rtl/core/etnf_div.sv @@
// ============================================================================
// etnf_div
// Pipelined restoring divider: splits the note index into a whole octave
// count and a Q62 fraction of an octave, and forms the cents offset.
// ============================================================================
module etnf_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [12:0]   in_note,
    input  logic [10:0]          divisor,
    output logic                 out_valid,
    output etnf_pkg::side_t      out_side,
    output logic [61:0]          out_frac
);

    localparam int STEPS_PER_STAGE = 4;
    localparam int INT_STAGES      = 4;
    localparam int CENTS_STAGES    = 8;
    localparam int FRAC_STAGES     = 16;
    localparam int LAST_STAGE      = INT_STAGES + FRAC_STAGES;

    typedef struct packed {
        logic               neg;
        logic [15:0]        int_num;
        logic [10:0]        int_rem;
        logic [15:0]        int_quo;
        logic [31:0]        c_num;
        logic [10:0]        c_rem;
        logic [31:0]        c_quo;
        logic [10:0]        f_rem;
        logic [63:0]        f_quo;
        logic signed [12:0] octave;
        logic signed [31:0] cents;
    } stage_t;

    stage_t               st_reg  [0:LAST_STAGE];
    stage_t               st_next [0:LAST_STAGE];
    logic [LAST_STAGE:0]  vld_reg;

    // Entry: magnitude of the index and the scaled cents dividend.
    always_comb begin
        logic [12:0] mag;
        mag = in_note[12] ? 13'(-in_note) : 13'(in_note);
        st_next[0]         = '0;
        st_next[0].neg     = in_note[12];
        st_next[0].int_num = 16'(mag);
        st_next[0].c_num   = 32'(32'(mag) * etnf_pkg::CENTS_SCALE);
    end

    // Division stages, four steps of each running division per stage.
    for (genvar j = 1; j <= LAST_STAGE; j++) begin : g_stage
        always_comb begin
            stage_t            s;
            logic [11:0]       r;
            logic signed [13:0] qs;
            s = st_reg[j-1];
            // Integer part of |n| / d.
            if (j <= INT_STAGES) begin
                for (int i = 0; i < STEPS_PER_STAGE; i++) begin
                    r = etnf_pkg::div_step(s.int_rem, s.int_num[15], divisor);
                    s.int_rem = r[10:0];
                    s.int_quo = {s.int_quo[14:0], r[11]};
                    s.int_num = {s.int_num[14:0], 1'b0};
                end
            end
            // Cents magnitude, |n| * 307200 / d.
            if (j <= CENTS_STAGES) begin
                for (int i = 0; i < STEPS_PER_STAGE; i++) begin
                    r = etnf_pkg::div_step(s.c_rem, s.c_num[31], divisor);
                    s.c_rem = r[10:0];
                    s.c_quo = {s.c_quo[30:0], r[11]};
                    s.c_num = {s.c_num[30:0], 1'b0};
                end
            end
            if (j == CENTS_STAGES + 1) begin
                s.cents = s.neg ? (32'd0 - s.c_quo) : s.c_quo;
            end
            // Floor the octave and fold the remainder for negative indexes.
            if (j == INT_STAGES + 1) begin
                qs = {1'b0, s.int_quo[12:0]};
                if (s.neg) begin
                    s.octave = 13'(-qs - 14'(s.int_rem != 11'd0));
                    s.f_rem  = (s.int_rem != 11'd0) ? 11'(divisor - s.int_rem) : 11'd0;
                end else begin
                    s.octave = 13'(qs);
                    s.f_rem  = s.int_rem;
                end
            end
            // Fraction bits of r / d.
            if (j > INT_STAGES) begin
                for (int i = 0; i < STEPS_PER_STAGE; i++) begin
                    r = etnf_pkg::div_step(s.f_rem, 1'b0, divisor);
                    s.f_rem = r[10:0];
                    s.f_quo = {s.f_quo[62:0], r[11]};
                end
            end
            st_next[j] = s;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST_STAGE-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= LAST_STAGE; j++) begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    assign out_valid       = vld_reg[LAST_STAGE];
    assign out_side.octave = st_reg[LAST_STAGE].octave;
    assign out_side.cents  = st_reg[LAST_STAGE].cents;
    assign out_frac        = st_reg[LAST_STAGE].f_quo[63:2];

endmodule

@@ rtl/core/etnf_exp.sv @@
// ============================================================================
// etnf_exp
// Pipelined Q62 evaluation of 2^f: a table lookup on the top fraction bits
// times a Taylor series of exp(ln2 * g) on the remaining bits.
// ============================================================================
module etnf_exp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [61:0]       in_frac,
    input  etnf_pkg::side_t   in_side,
    output logic              out_valid,
    output logic [63:0]       out_mant,
    output etnf_pkg::side_t   out_side
);

    localparam int TERMS      = etnf_pkg::SERIES_TERMS;
    localparam int LOW_BITS   = 62 - etnf_pkg::TABLE_ADDR_BITS;
    localparam int REM_BITS   = etnf_pkg::REM_BITS;
    localparam int CUR_BITS   = REM_BITS + 16;
    localparam int MAGIC_BITS = REM_BITS + 18;
    localparam int PROD_BITS  = CUR_BITS + MAGIC_BITS;

    typedef struct packed {
        etnf_pkg::side_t side;
        logic [63:0]     tab;
        logic [63:0]     x;
        logic [63:0]     acc;
    } carry_t;

    // Argument stage: ln2 * g partials and the table read.
    etnf_pkg::parts_t  arg_parts_reg;
    logic [63:0]       arg_tab_reg;
    etnf_pkg::side_t   arg_side_reg;
    logic              arg_vld_reg;

    // Series stages per term: partials, rounded product, upper half of the
    // division by the term number, lower half giving the new term.
    carry_t              d_carry_reg [0:TERMS];
    logic [63:0]         d_term_reg  [0:TERMS];
    logic [TERMS:0]      d_vld_reg;
    carry_t              m1_carry_reg [1:TERMS];
    etnf_pkg::parts_t    m1_parts_reg [1:TERMS];
    logic [TERMS:1]      m1_vld_reg;
    carry_t              m2_carry_reg [1:TERMS];
    logic [63:0]         m2_prod_reg  [1:TERMS];
    logic [TERMS:1]      m2_vld_reg;
    carry_t              v_carry_reg  [1:TERMS];
    logic [31:0]         v_quo_reg    [1:TERMS];
    logic [REM_BITS-1:0] v_rem_reg    [1:TERMS];
    logic [31:0]         v_low_reg    [1:TERMS];
    logic [TERMS:1]      v_vld_reg;

    // Tail: series sum, table times sum.
    logic [63:0]       sum_reg;
    logic [63:0]       sum_tab_reg;
    etnf_pkg::side_t   sum_side_reg;
    logic              sum_vld_reg;
    etnf_pkg::parts_t  fin_parts_reg;
    etnf_pkg::side_t   fin_side_reg;
    logic              fin_vld_reg;
    logic [63:0]       mant_reg;
    etnf_pkg::side_t   mant_side_reg;
    logic              mant_vld_reg;

    // One 16-bit digit of a division by a small constant. The quotient comes
    // from a reciprocal multiply that is exact for every dividend below
    // divisor * 2^16; the remainder comes from multiplying back.
    function automatic logic [15+REM_BITS:0] div_digit(logic [REM_BITS-1:0] rem,
                                                       logic [15:0] digit,
                                                       logic [MAGIC_BITS-1:0] magic,
                                                       int shift, int divisor);
        logic [CUR_BITS-1:0]  cur;
        logic [PROD_BITS-1:0] prod;
        logic [15:0]          quo;
        cur  = {rem, digit};
        prod = PROD_BITS'(cur) * PROD_BITS'(magic);
        quo  = 16'(prod >> shift);
        return {quo, REM_BITS'(cur - CUR_BITS'(quo) * CUR_BITS'(divisor))};
    endfunction

    // Table read and argument partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            arg_parts_reg <= etnf_pkg::mul_parts(64'(in_frac[LOW_BITS-1:0]),
                                                 etnf_pkg::LN2_Q62);
            arg_tab_reg   <= etnf_pkg::POW_TABLE[in_frac[61 -: etnf_pkg::TABLE_ADDR_BITS]];
            arg_side_reg  <= in_side;
        end
    end

    // Series entry: term one, empty sum, rounded argument.
    always_ff @(posedge aclk) begin
        if (en) begin
            d_carry_reg[0].side <= arg_side_reg;
            d_carry_reg[0].tab  <= arg_tab_reg;
            d_carry_reg[0].x    <= etnf_pkg::mul_round(arg_parts_reg);
            d_carry_reg[0].acc  <= '0;
            d_term_reg[0]       <= etnf_pkg::Q62_ONE;
        end
    end

    for (genvar k = 1; k <= TERMS; k++) begin : g_term
        localparam int DIVISOR   = k;
        localparam int DIV_SHIFT = CUR_BITS + $clog2(k);
        localparam logic [MAGIC_BITS-1:0] DIV_MAGIC =
            MAGIC_BITS'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
        logic [31:0]         quo_hi_next;
        logic [REM_BITS-1:0] rem_hi_next;
        logic [31:0]         quo_lo_next;

        // Upper half of the product divided by the term number.
        always_comb begin
            logic [15+REM_BITS:0] dq;
            logic [REM_BITS-1:0]  rem;
            rem         = '0;
            quo_hi_next = '0;
            for (int b = 1; b >= 0; b--) begin
                dq = div_digit(rem, m2_prod_reg[k][32 + b*16 +: 16],
                               DIV_MAGIC, DIV_SHIFT, DIVISOR);
                quo_hi_next[b*16 +: 16] = dq[15+REM_BITS -: 16];
                rem = dq[REM_BITS-1:0];
            end
            rem_hi_next = rem;
        end

        // Lower half, continuing from the upper remainder.
        always_comb begin
            logic [15+REM_BITS:0] dq;
            logic [REM_BITS-1:0]  rem;
            rem         = v_rem_reg[k];
            quo_lo_next = '0;
            for (int b = 1; b >= 0; b--) begin
                dq = div_digit(rem, v_low_reg[k][b*16 +: 16],
                               DIV_MAGIC, DIV_SHIFT, DIVISOR);
                quo_lo_next[b*16 +: 16] = dq[15+REM_BITS -: 16];
                rem = dq[REM_BITS-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                m1_carry_reg[k].side <= d_carry_reg[k-1].side;
                m1_carry_reg[k].tab  <= d_carry_reg[k-1].tab;
                m1_carry_reg[k].x    <= d_carry_reg[k-1].x;
                m1_carry_reg[k].acc  <= d_carry_reg[k-1].acc + d_term_reg[k-1];
                m1_parts_reg[k]      <= etnf_pkg::mul_parts(d_term_reg[k-1],
                                                            d_carry_reg[k-1].x);
                m2_carry_reg[k]      <= m1_carry_reg[k];
                m2_prod_reg[k]       <= etnf_pkg::mul_round(m1_parts_reg[k]);
                v_carry_reg[k]       <= m2_carry_reg[k];
                v_quo_reg[k]         <= quo_hi_next;
                v_rem_reg[k]         <= rem_hi_next;
                v_low_reg[k]         <= m2_prod_reg[k][31:0];
                d_carry_reg[k]       <= v_carry_reg[k];
                d_term_reg[k]        <= {v_quo_reg[k], quo_lo_next};
            end
        end
    end

    // Series sum, then table value times sum.
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg       <= d_carry_reg[TERMS].acc + d_term_reg[TERMS];
            sum_tab_reg   <= d_carry_reg[TERMS].tab;
            sum_side_reg  <= d_carry_reg[TERMS].side;
            fin_parts_reg <= etnf_pkg::mul_parts(sum_tab_reg, sum_reg);
            fin_side_reg  <= sum_side_reg;
            mant_reg      <= etnf_pkg::mul_round(fin_parts_reg);
            mant_side_reg <= fin_side_reg;
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arg_vld_reg  <= 1'b0;
            d_vld_reg    <= '0;
            m1_vld_reg   <= '0;
            m2_vld_reg   <= '0;
            v_vld_reg    <= '0;
            sum_vld_reg  <= 1'b0;
            fin_vld_reg  <= 1'b0;
            mant_vld_reg <= 1'b0;
        end else if (en) begin
            arg_vld_reg  <= in_valid;
            d_vld_reg    <= {v_vld_reg, arg_vld_reg};
            m1_vld_reg   <= d_vld_reg[TERMS-1:0];
            m2_vld_reg   <= m1_vld_reg;
            v_vld_reg    <= m2_vld_reg;
            sum_vld_reg  <= d_vld_reg[TERMS];
            fin_vld_reg  <= sum_vld_reg;
            mant_vld_reg <= fin_vld_reg;
        end
    end

    assign out_valid = mant_vld_reg;
    assign out_mant  = mant_reg;
    assign out_side  = mant_side_reg;

endmodule

@@ rtl/core/equal_temperament_note_to_frequency.sv @@
// ============================================================================
// equal_temperament_note_to_frequency
// Converts a signed note index into root * 2^(n/d) in Q16.16 and the cents
// offset 1200*n/d with eight fraction bits.
// ============================================================================
// Usage:
//   s_tdata carries the 13-bit signed note index in bits [12:0]. Each result
//   item carries the frequency in m_tdata[31:0], the cents offset in
//   m_tdata[63:32] and the saturation flag in m_tuser[0].
//   The configuration channel writes steps_per_octave (index 0) and
//   root_frequency (index 1); write only while no item is in flight.
//   Throughput is one item per clock while the output buffer is not full. The
//   pipeline depth comes from the 64-step fraction divider and the 24-term
//   exp series, four stages per term: a 32x32 multiplier array, its rounding,
//   and two stages of division by the term number.
//   Reset clears every valid bit and loads 12 steps and a 440 Hz root.
//   When m_tready is low the pipeline keeps running into a two-entry output
//   buffer; once both entries are held, s_tready drops and every stage holds.
// ============================================================================
module equal_temperament_note_to_frequency (
    input  logic         aclk,
    input  logic         aresetn,
    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [12:0] note_index, [15:13] zero
    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // [31:0] frequency, [63:32] cents_offset
    output logic [0:0]   m_tuser,   // [0] overflowed
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef struct packed {
        logic        ovf;
        logic [31:0] cents;
        logic [31:0] freq;
    } result_t;

    logic [10:0]      steps_reg;
    logic [31:0]      root_reg;
    logic [10:0]      divisor;
    logic             en;
    logic             in_valid;

    logic             div_valid;
    etnf_pkg::side_t  div_side;
    logic [61:0]      div_frac;
    logic             exp_valid;
    logic [63:0]      exp_mant;
    etnf_pkg::side_t  exp_side;

    logic             s1_vld_reg;
    logic [63:0]      s1_ph_reg;
    logic [63:0]      s1_pl_reg;
    etnf_pkg::side_t  s1_side_reg;
    logic             s2_vld_reg;
    logic [95:0]      s2_prod_reg;
    logic signed [13:0] s2_shift_reg;
    logic [31:0]      s2_cents_reg;
    logic             s3_vld_reg;
    logic [96:0]      s3_round_reg;
    logic [6:0]       s3_shamt_reg;
    logic             s3_zero_reg;
    logic             s3_sat_reg;
    logic             s3_under_reg;
    logic [31:0]      s3_cents_reg;
    logic             p_vld_reg;
    result_t          p_data_reg;
    result_t          p_data_next;

    logic             out_valid_reg;
    result_t          out_data_reg;
    logic             skid_valid_reg;
    result_t          skid_data_reg;

    // Configuration registers.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= etnf_pkg::STEPS_RESET;
            root_reg  <= etnf_pkg::ROOT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (etnf_pkg::cfg_reg_t'(cfg_index))
                etnf_pkg::REG_STEPS_PER_OCTAVE: steps_reg <= cfg_data[10:0];
                etnf_pkg::REG_ROOT_FREQUENCY:   root_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // A zero division count behaves as one.
    assign divisor = (steps_reg == 11'd0) ? 11'd1 : steps_reg;

    // The whole pipeline advances unless the output buffer is full.
    assign en       = !skid_valid_reg;
    assign s_tready = aresetn && en;
    assign in_valid = s_tvalid && s_tready;

    etnf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid),
        .in_note   ($signed(s_tdata[12:0])),
        .divisor   (divisor),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_frac  (div_frac)
    );

    etnf_exp u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .in_frac   (div_frac),
        .in_side   (div_side),
        .out_valid (exp_valid),
        .out_mant  (exp_mant),
        .out_side  (exp_side)
    );

    // Root times mantissa, rounding and octave shift.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ph_reg    <= 64'(root_reg) * 64'(exp_mant[63:32]);
            s1_pl_reg    <= 64'(root_reg) * 64'(exp_mant[31:0]);
            s1_side_reg  <= exp_side;

            s2_prod_reg  <= {s1_ph_reg[63:0], 32'd0} + {32'd0, s1_pl_reg};
            s2_shift_reg <= 14'sd62 - 14'(s1_side_reg.octave);
            s2_cents_reg <= s1_side_reg.cents;

            s3_zero_reg  <= (s2_prod_reg == 96'd0);
            s3_sat_reg   <= (s2_shift_reg <= 14'sd0);
            s3_under_reg <= (s2_shift_reg > 14'sd96);
            s3_shamt_reg <= s2_shift_reg[6:0];
            s3_round_reg <= 97'(s2_prod_reg) + (97'd1 << 7'(s2_shift_reg[6:0] - 7'd1));
            s3_cents_reg <= s2_cents_reg;

            p_data_reg   <= p_data_next;
        end
    end

    // Final classification of the shifted product.
    always_comb begin
        logic [96:0] shifted;
        shifted           = s3_round_reg >> s3_shamt_reg;
        p_data_next.cents = s3_cents_reg;
        priority if (s3_zero_reg) begin
            p_data_next.freq = 32'd0;
            p_data_next.ovf  = 1'b0;
        end else if (s3_sat_reg) begin
            p_data_next.freq = etnf_pkg::FREQ_MAX;
            p_data_next.ovf  = 1'b1;
        end else if (s3_under_reg) begin
            p_data_next.freq = 32'd0;
            p_data_next.ovf  = 1'b0;
        end else if (shifted[96:32] != 65'd0) begin
            p_data_next.freq = etnf_pkg::FREQ_MAX;
            p_data_next.ovf  = 1'b1;
        end else begin
            p_data_next.freq = shifted[31:0];
            p_data_next.ovf  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            p_vld_reg  <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= exp_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            p_vld_reg  <= s3_vld_reg;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= p_vld_reg;
        end else if (p_vld_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_data_reg <= p_data_reg;
        end else begin
            skid_data_reg <= p_data_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_data_reg.cents, out_data_reg.freq};
    assign m_tuser[0] = out_data_reg.ovf;

    // The skid entry is only ever filled behind a held output item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output is empty");

    // A taken output frees the skid entry by the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_tready |=> !skid_valid_reg)
        else $error("skid entry not drained after output was taken");

    // Saturation always comes with an all-ones frequency.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == etnf_pkg::FREQ_MAX)
        else $error("overflow flag without saturated frequency");

    // A zero root yields a zero frequency and no overflow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && root_reg == 32'd0 |-> m_tdata[31:0] == 32'd0 && !m_tuser[0])
        else $error("nonzero frequency from a zero root");

endmodule
